FILE: rtl/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

  localparam int SPEED_POINTS    = 7;
  localparam int POSITION_POINTS = 5;

  localparam int SPD_FRAC_W = 8;   // speed input is 1/256 mph
  localparam int SPD_IN_W   = 14;
  localparam int POS_IN_W   = 16;
  localparam int PW_W       = 16;
  localparam int SPD_GRID_W = 6;
  localparam int POS_W      = 10;
  localparam int WATT_W     = 12;

  // Segment and ROM index widths
  localparam int XI_W = $clog2(SPEED_POINTS - 1);
  localparam int YI_W = $clog2(POSITION_POINTS - 1);
  localparam int XR_W = $clog2(SPEED_POINTS);
  localparam int YR_W = $clog2(POSITION_POINTS);

  // Datapath widths sized for the grid below
  localparam int DX_W        = 13;  // widest speed segment is 25 mph = 6400
  localparam int DY_W        = 8;   // position segment is 250
  localparam int AB_W        = 20;  // 3324 * 250
  localparam int NUM_W       = 33;  // 3324 * 250 * 6400
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 18;  // 2^32 / 20000
  localparam int DIV_W       = 17;  // 16 * 25 * 250
  localparam int Q_W         = 17;
  localparam int R_W         = 19;  // remainder stays below three divisors

  localparam logic [SPD_GRID_W-1:0] SPEED_GRID [SPEED_POINTS] =
    '{6'd0, 6'd5, 6'd10, 6'd15, 6'd20, 6'd25, 6'd50};

  localparam logic [POS_W-1:0] POS_GRID [POSITION_POINTS] =
    '{10'd0, 10'd250, 10'd500, 10'd750, 10'd1000};

  localparam logic [WATT_W-1:0] WATT_ROM [SPEED_POINTS][POSITION_POINTS] = '{
    '{12'd0,   12'd0,    12'd0,    12'd0,    12'd0   },
    '{12'd52,  12'd68,   12'd80,   12'd102,  12'd124 },
    '{12'd117, 12'd143,  12'd217,  12'd280,  12'd343 },
    '{12'd188, 12'd246,  12'd383,  12'd490,  12'd597 },
    '{12'd265, 12'd380,  12'd580,  12'd732,  12'd884 },
    '{12'd349, 12'd544,  12'd806,  12'd1006, 12'd1206},
    '{12'd861, 12'd1806, 12'd2388, 12'd2856, 12'd3324}
  };

  localparam logic [PW_W-1:0] PW_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SPEED = 2'd1,
    STATUS_POS   = 2'd2
  } status_t;

  typedef struct packed {
    logic        [SPD_IN_W-1:0] speed_mph;
    logic signed [POS_IN_W-1:0] position;
  } sample_t;

  typedef struct packed {
    logic [PW_W-1:0] power_watts;
    status_t         status;
  } result_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [XI_W-1:0]  xi;
    logic [YI_W-1:0]  yi;
    status_t          status;
  } div_req_t;

  function automatic logic [SPD_IN_W-1:0] speed_pt(input logic [XR_W-1:0] idx);
    return {SPEED_GRID[idx], {SPD_FRAC_W{1'b0}}};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bpc_div.sv
`default_nettype none

// Pipelined exact floor(num / K) where K = 16 * speed step (mph) * position step
// for the selected segment. Reciprocal multiply, back-multiply, then up to two
// correction steps.
module bpc_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire bpc_pkg::div_req_t req,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output bpc_pkg::result_t       result
);
  import bpc_pkg::*;

  localparam int PROD_W = NUM_W + RECIP_W;

  logic [DIV_W-1:0]   div_tab   [SPEED_POINTS-1][POSITION_POINTS-1];
  logic [RECIP_W-1:0] recip_tab [SPEED_POINTS-1][POSITION_POINTS-1];

  for (genvar gx = 0; gx < SPEED_POINTS - 1; gx++) begin : g_x
    for (genvar gy = 0; gy < POSITION_POINTS - 1; gy++) begin : g_y
      localparam longint unsigned KV = 64'd16
        * longint'(int'(SPEED_GRID[gx+1] - SPEED_GRID[gx]))
        * longint'(int'(POS_GRID[gy+1] - POS_GRID[gy]));
      localparam longint unsigned MV = (64'd1 << RECIP_SHIFT) / KV;
      assign div_tab[gx][gy]   = DIV_W'(KV);
      assign recip_tab[gx][gy] = RECIP_W'(MV);
    end
  end

  // stage 5: quotient estimate
  logic             v5, v6;
  div_req_t         r5, r6;
  logic [Q_W-1:0]   q0_5, q0_6;
  logic [NUM_W-1:0] qk6;
  logic             en5, en6, en7;

  logic [PROD_W-1:0] prod;
  logic [R_W-1:0]    rem, k1, k2;
  logic [Q_W-1:0]    q;
  logic [PW_W-1:0]   pw;

  assign en7       = !result_valid || !result_stall;
  assign en6       = !v6 || en7;
  assign en5       = !v5 || en6;
  assign req_stall = !en5;

  assign prod = PROD_W'(req.num) * PROD_W'(recip_tab[req.xi][req.yi]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= req_valid;
    end
    if (en5) begin
      r5   <= req;
      q0_5 <= Q_W'(prod >> RECIP_SHIFT);
    end
  end

  // stage 6: back-multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en6) begin
      v6 <= v5;
    end
    if (en6) begin
      r6   <= r5;
      q0_6 <= q0_5;
      qk6  <= NUM_W'(NUM_W'(q0_5) * NUM_W'(div_tab[r5.xi][r5.yi]));
    end
  end

  // stage 7: estimate is low by at most two
  always_comb begin
    k1  = R_W'(div_tab[r6.xi][r6.yi]);
    k2  = R_W'({div_tab[r6.xi][r6.yi], 1'b0});
    rem = R_W'(r6.num - qk6);
    if (rem >= k2) begin
      q = q0_6 + Q_W'(2);
    end else if (rem >= k1) begin
      q = q0_6 + Q_W'(1);
    end else begin
      q = q0_6;
    end
    if (q > Q_W'(PW_MAX)) begin
      pw = PW_MAX;
    end else begin
      pw = PW_W'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en7) begin
      result_valid <= v6;
    end
    if (en7) begin
      result.status      <= r6.status;
      result.power_watts <= (r6.status == STATUS_OK) ? pw : '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bilinear_power_calibration.sv
`default_nettype none
// Throughput: one item per cycle when the output is not stalled; seven register
//   stages (segment search, corner blend, two products, sum, reciprocal multiply,
//   back-multiply, correct).
// A stalled result holds; bubbles between stages fill while the output waits.
// Reset (synchronous) clears the stage valid bits only; the data registers are not reset.
module bilinear_power_calibration (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             sample_valid,
  output logic                  sample_stall,
  input  wire bpc_pkg::sample_t sample,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output bpc_pkg::result_t      result
);
  import bpc_pkg::*;

  logic en1, en2, en3, en4;
  logic v1, v2, v3, v4;
  logic div_stall;

  // stage 1: range check and segment search
  status_t          st1_next, st1, st2, st3;
  logic [XI_W-1:0]  xi1_next, xi1, xi2, xi3;
  logic [YI_W-1:0]  yi1_next, yi1, yi2, yi3;
  logic [DX_W-1:0]  dx1_next, dx1, dx2;
  logic [DY_W-1:0]  dy1_next, dy1;
  logic [POS_W-1:0] pv;

  // stage 2: corner blend along position
  logic [XR_W-1:0]     x0, x1;
  logic [YR_W-1:0]     y0, y1;
  logic [DY_W-1:0]     bymdy;
  logic [SPD_IN_W-1:0] bx;
  logic [AB_W-1:0]     a_next, b_next, a2, b2;
  logic [DX_W-1:0]     bxmdx_next, bxmdx2;

  // stage 3/4
  logic [NUM_W-1:0] p1, p2;
  div_req_t         req4;

  assign en4          = !v4 || !div_stall;
  assign en3          = !v3 || en4;
  assign en2          = !v2 || en3;
  assign en1          = !v1 || en2;
  assign sample_stall = !en1;

  always_comb begin
    pv       = sample.position[POS_W-1:0];
    st1_next = STATUS_OK;
    if (sample.speed_mph > speed_pt(XR_W'(SPEED_POINTS - 1)) ||
        sample.speed_mph < speed_pt(XR_W'(0))) begin
      st1_next = STATUS_SPEED;
    end else if (sample.position < $signed({6'd0, POS_GRID[0]}) ||
                 sample.position > $signed({6'd0, POS_GRID[POSITION_POINTS-1]})) begin
      st1_next = STATUS_POS;
    end
    // top grid point lands in the last segment
    xi1_next = '0;
    for (int i = 1; i < SPEED_POINTS - 1; i++) begin
      if (sample.speed_mph >= speed_pt(XR_W'(i))) xi1_next = XI_W'(i);
    end
    yi1_next = '0;
    for (int i = 1; i < POSITION_POINTS - 1; i++) begin
      if (pv >= POS_GRID[i]) yi1_next = YI_W'(i);
    end
    dx1_next = DX_W'(sample.speed_mph - speed_pt(XR_W'(xi1_next)));
    dy1_next = DY_W'(pv - POS_GRID[YR_W'(yi1_next)]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= sample_valid;
    end
    if (en1) begin
      st1 <= st1_next;
      xi1 <= xi1_next;
      yi1 <= yi1_next;
      dx1 <= dx1_next;
      dy1 <= dy1_next;
    end
  end

  always_comb begin
    x0    = XR_W'(xi1);
    x1    = XR_W'(xi1) + XR_W'(1);
    y0    = YR_W'(yi1);
    y1    = YR_W'(yi1) + YR_W'(1);
    bymdy = DY_W'(POS_GRID[y1] - POS_GRID[y0]) - dy1;
    bx    = {SPEED_GRID[x1] - SPEED_GRID[x0], {SPD_FRAC_W{1'b0}}};
    bxmdx_next = DX_W'(bx - SPD_IN_W'(dx1));
    a_next = AB_W'(WATT_ROM[x0][y0]) * AB_W'(bymdy)
           + AB_W'(WATT_ROM[x0][y1]) * AB_W'(dy1);
    b_next = AB_W'(WATT_ROM[x1][y0]) * AB_W'(bymdy)
           + AB_W'(WATT_ROM[x1][y1]) * AB_W'(dy1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      st2    <= st1;
      xi2    <= xi1;
      yi2    <= yi1;
      dx2    <= dx1;
      bxmdx2 <= bxmdx_next;
      a2     <= a_next;
      b2     <= b_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      st3 <= st2;
      xi3 <= xi2;
      yi3 <= yi2;
      p1  <= NUM_W'(a2) * NUM_W'(bxmdx2);
      p2  <= NUM_W'(b2) * NUM_W'(dx2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
    if (en4) begin
      req4.num    <= p1 + p2;
      req4.xi     <= xi3;
      req4.yi     <= yi3;
      req4.status <= st3;
    end
  end

  bpc_div u_div (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (v4),
    .req_stall    (div_stall),
    .req          (req4),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

FILE: rtl/bpc_checker.sv
`default_nettype none

module bpc_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             sample_valid,
  input wire logic             sample_stall,
  input wire bpc_pkg::sample_t sample,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire bpc_pkg::result_t result
);
  import bpc_pkg::*;

  // largest corner is 3324 W, so 53184 in 1/16 W
  localparam logic [PW_W-1:0] PW_TOP = 16'd53184;

  a_sample_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_stall |=> sample_valid && $stable(sample))
    else $error("stalled input item changed");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != STATUS_OK |-> result.power_watts == '0)
    else $error("out-of-range item has nonzero power");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.power_watts <= PW_TOP)
    else $error("power above largest calibration point");

  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind bilinear_power_calibration bpc_checker u_bpc_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .sample       (sample),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
